[rtl/core/gpw_pkg.sv]
// ============================================================================
// gpw_pkg: shared types and constants of the GNSS particle weighting core
// Field widths, pipeline side-band structs, register indexes and the
// reciprocal table used by the Taylor series divisions.
// ============================================================================
package gpw_pkg;

    // Field and datapath widths
    localparam int COORD_W   = 25;   // particle and fix coordinates
    localparam int AX_W      = 25;   // absolute coordinate difference
    localparam int SQ_W      = 50;   // square of one difference
    localparam int D2_W      = 51;   // dx^2 + dy^2
    localparam int D2_SHIFT  = 12;   // d2 * 4096 moves to units of 1/16384 m
    localparam int RAD_W     = 26;   // radius and spread in units of 1/16384 m
    localparam int RAD2_W    = 52;   // square of the radius
    localparam int REM_W     = 64;   // square root remainder
    localparam int ROOT_W    = 32;   // square root result
    localparam int FRAC_W    = 16;   // Q16 fraction of the normalised excess
    localparam int QUO_W     = 19;   // quotient bits kept below the tail test
    localparam int DREM_W    = ROOT_W + FRAC_W;
    localparam int A2_W      = 2 * QUO_W;
    localparam int T_SHIFT   = 17;   // a*a / 2^17 gives t in Q16
    localparam int T_W       = A2_W - T_SHIFT;
    localparam int N_W       = T_W - FRAC_W;
    localparam int TERM_W    = 31;
    localparam int RECIP_W   = 32;
    localparam int SUM_W     = 33;
    localparam int ACC_W     = 31;
    localparam int E1_W      = 29;
    localparam int Q30_SHIFT = 30;
    localparam int Q16_SHIFT = 14;   // Q30 down to Q16
    localparam int WEIGHT_W  = 17;
    localparam int CFG_W     = 17;
    localparam int GAIN_W    = 8;
    localparam int PARAM_W   = 16;
    localparam int NUM_TERMS = 12;   // Taylor degree for exp(-f)
    localparam int NUM_EXP   = 12;   // most whole steps of e^-1 needed

    // Constants
    localparam logic [TERM_W-1:0]   ONE_Q30    = 31'd1073741824;
    localparam logic [E1_W-1:0]     E1_Q30     = 29'd395007542;
    localparam logic [QUO_W-1:0]    TAIL_Q16   = 19'd327680;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam logic [ACC_W:0]      ROUND_HALF = 32'd8192;

    // Register indexes of the configuration port
    typedef enum logic [1:0] {
        REG_CORE_RADIUS = 2'd0,
        REG_SIGMA_SCALE = 2'd1,
        REG_MIN_WEIGHT  = 2'd2,
        REG_FLOAT_GAIN  = 2'd3
    } cfg_reg_t;

    // Item held in the queue between front and back
    typedef struct packed {
        logic [D2_W-1:0]  d2;
        logic             core;
        logic [RAD_W-1:0] r64;
        logic [RAD_W-1:0] s64;
    } fq_item_t;

    // Side band along the square root stages
    typedef struct packed {
        logic             core;
        logic [RAD_W-1:0] r64;
        logic [RAD_W-1:0] s64;
    } sq_side_t;

    // Side band along the divider stages
    typedef struct packed {
        logic             core;
        logic             tail;
        logic [RAD_W-1:0] s64;
    } dv_side_t;

    // Outcome flags that bypass the Gaussian value
    typedef struct packed {
        logic core;
        logic tail;
    } res_flags_t;

    // Side band along the exponential stages
    typedef struct packed {
        res_flags_t        flags;
        logic [N_W-1:0]    n;
        logic [FRAC_W-1:0] f;
    } gs_side_t;

    // floor((2^32 - 1) / k): a low estimate of 1/k, fixed up by one compare
    function automatic logic [RECIP_W-1:0] recip_q32(input int k);
        case (k)
            1:       return 32'd4294967295;
            2:       return 32'd2147483647;
            3:       return 32'd1431655765;
            4:       return 32'd1073741823;
            5:       return 32'd858993459;
            6:       return 32'd715827882;
            7:       return 32'd613566756;
            8:       return 32'd536870911;
            9:       return 32'd477218588;
            10:      return 32'd429496729;
            11:      return 32'd390451572;
            12:      return 32'd357913941;
            default: return 32'd0;
        endcase
    endfunction

endpackage

[rtl/core/gnss_particle_weighting_core.sv]
// ============================================================================
// gnss_particle_weighting_core: particle weight from distance to a GNSS fix
// Gaussian likelihood with a flat core and a lower clamp, Q1.16 result.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_ready) carries one particle position, the
//   fix position and the carrier_fixed flag per beat. Output channel
//   (out_valid / out_ready) returns one weight per input beat, in order.
//   One beat is accepted every cycle while in_ready is high; the core is fully
//   pipelined. An input beat passes through 3 front stages, 1 queue, 32
//   square-root stages (one root bit each), 20 divider stages (the excess,
//   then one quotient bit each), 1 squaring stage, 36 Taylor stages (three
//   per term), 12 e^-1 stages and the output register.
//   When the receiver stalls, the back pipeline holds while the front keeps
//   taking beats into the queue (QUEUE_DEPTH deep); in_ready drops once the
//   queue is full and the last front stage holds a beat.
//   Configuration: write cfg_wdata to register cfg_addr with cfg_wr_en, only
//   while no beat is in flight. Reset loads core radius 256, sigma_scale
//   6400, min_weight 655, float_gain 32 and empties every stage.
// ============================================================================
module gnss_particle_weighting_core #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [gpw_pkg::COORD_W-1:0]   particle_x,
    input  logic signed [gpw_pkg::COORD_W-1:0]   particle_y,
    input  logic signed [gpw_pkg::COORD_W-1:0]   gnss_x,
    input  logic signed [gpw_pkg::COORD_W-1:0]   gnss_y,
    input  logic                                 carrier_fixed,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [gpw_pkg::WEIGHT_W-1:0]  weight,
    input  logic                                 cfg_wr_en,
    input  logic        [1:0]                    cfg_addr,
    input  logic        [gpw_pkg::CFG_W-1:0]     cfg_wdata
);

    // Configuration registers
    logic [gpw_pkg::PARAM_W-1:0]  core_radius_reg;
    logic [gpw_pkg::PARAM_W-1:0]  sigma_scale_reg;
    logic [gpw_pkg::WEIGHT_W-1:0] min_weight_reg;
    logic [gpw_pkg::GAIN_W-1:0]   float_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            core_radius_reg <= 16'd256;
            sigma_scale_reg <= 16'd6400;
            min_weight_reg  <= 17'd655;
            float_gain_reg  <= 8'd32;
        end
        else if (cfg_wr_en)
        begin
            case (gpw_pkg::cfg_reg_t'(cfg_addr))
                gpw_pkg::REG_CORE_RADIUS: core_radius_reg <= cfg_wdata[gpw_pkg::PARAM_W-1:0];
                gpw_pkg::REG_SIGMA_SCALE: sigma_scale_reg <= cfg_wdata[gpw_pkg::PARAM_W-1:0];
                gpw_pkg::REG_MIN_WEIGHT:  min_weight_reg  <= cfg_wdata;
                gpw_pkg::REG_FLOAT_GAIN:  float_gain_reg  <= cfg_wdata[gpw_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // Front, queue, back
    logic              push_valid, push_ready, pop_valid;
    gpw_pkg::fq_item_t push_item, pop_item;
    logic              back_en;
    logic              bk_valid;
    logic [gpw_pkg::T_W-1:0] bk_t;
    gpw_pkg::res_flags_t     bk_flags;
    logic              gs_valid;
    logic [gpw_pkg::ACC_W-1:0] gs_acc;
    gpw_pkg::res_flags_t       gs_flags;

    gpw_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .particle_x    (particle_x),
        .particle_y    (particle_y),
        .gnss_x        (gnss_x),
        .gnss_y        (gnss_y),
        .carrier_fixed (carrier_fixed),
        .core_radius   (core_radius_reg),
        .sigma_scale   (sigma_scale_reg),
        .float_gain    (float_gain_reg),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    gpw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (back_en),
        .pop_item   (pop_item)
    );

    gpw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (pop_valid),
        .in_item   (pop_item),
        .out_valid (bk_valid),
        .out_t     (bk_t),
        .out_flags (bk_flags)
    );

    gpw_gauss u_gauss (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (back_en),
        .in_valid  (bk_valid),
        .in_t      (bk_t),
        .in_flags  (bk_flags),
        .out_valid (gs_valid),
        .out_acc   (gs_acc),
        .out_flags (gs_flags)
    );

    // Output register: round to Q16, pick core / tail, clamp from below
    logic                         out_valid_reg;
    logic [gpw_pkg::WEIGHT_W-1:0] weight_reg, weight_next;
    logic [gpw_pkg::ACC_W:0]      rounded;
    logic [gpw_pkg::WEIGHT_W-1:0] gauss_w, raw_w;

    assign back_en = !out_valid_reg || out_ready;
    assign rounded = (gpw_pkg::ACC_W + 1)'(gs_acc) + gpw_pkg::ROUND_HALF;
    assign gauss_w = rounded[gpw_pkg::ACC_W-1:gpw_pkg::Q16_SHIFT];
    assign raw_w   = gs_flags.core ? gpw_pkg::WEIGHT_ONE
                   : (gs_flags.tail ? '0 : gauss_w);
    assign weight_next = (raw_w < min_weight_reg) ? min_weight_reg : raw_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (back_en)
        begin
            out_valid_reg <= gs_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (back_en)
        begin
            weight_reg <= weight_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign weight    = weight_reg;

endmodule

[rtl/core/gpw_front.sv]
// ============================================================================
// gpw_front: intake and core classification
// Takes particle and fix positions, forms the squared distance, the
// effective radius and spread, and flags items inside the flat core.
// ============================================================================
module gpw_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [gpw_pkg::COORD_W-1:0]   particle_x,
    input  logic signed [gpw_pkg::COORD_W-1:0]   particle_y,
    input  logic signed [gpw_pkg::COORD_W-1:0]   gnss_x,
    input  logic signed [gpw_pkg::COORD_W-1:0]   gnss_y,
    input  logic                                 carrier_fixed,
    input  logic        [gpw_pkg::PARAM_W-1:0]   core_radius,
    input  logic        [gpw_pkg::PARAM_W-1:0]   sigma_scale,
    input  logic        [gpw_pkg::GAIN_W-1:0]    float_gain,
    output logic                                 push_valid,
    input  logic                                 push_ready,
    output gpw_pkg::fq_item_t                    push_item
);

    localparam int DX_W   = gpw_pkg::COORD_W + 1;
    localparam int PG_W   = gpw_pkg::PARAM_W + gpw_pkg::GAIN_W;
    localparam int FIX_SH = 6;   // x64 in carrier-fixed mode
    localparam int FLT_SH = 2;   // x4 after the Q4.4 gain

    logic                        en;
    logic                        v1_reg, v2_reg, v3_reg;
    logic signed [DX_W-1:0]      dx, dy;
    logic [gpw_pkg::AX_W-1:0]    ax_next, ay_next;
    logic [PG_W-1:0]             rg, sg;
    logic [gpw_pkg::RAD_W-1:0]   r64_next, s64_next;

    logic [gpw_pkg::AX_W-1:0]    ax_reg, ay_reg;
    logic [gpw_pkg::RAD_W-1:0]   r64_1_reg, s64_1_reg;
    logic [gpw_pkg::SQ_W-1:0]    ax2_reg, ay2_reg;
    logic [gpw_pkg::RAD2_W-1:0]  r2_reg;
    logic [gpw_pkg::RAD_W-1:0]   r64_2_reg, s64_2_reg;
    logic [gpw_pkg::D2_W-1:0]    d2_next;
    logic [gpw_pkg::REM_W-1:0]   d2s;
    gpw_pkg::fq_item_t           item_reg;

    // Advance unless the last stage holds an item the queue cannot take
    assign en       = !v3_reg || push_ready;
    assign in_ready = en;

    // Stage 1: differences and effective radius / spread
    assign dx = DX_W'(particle_x) - DX_W'(gnss_x);
    assign dy = DX_W'(particle_y) - DX_W'(gnss_y);
    assign ax_next = dx[DX_W-1] ? gpw_pkg::AX_W'(-dx) : gpw_pkg::AX_W'(dx);
    assign ay_next = dy[DX_W-1] ? gpw_pkg::AX_W'(-dy) : gpw_pkg::AX_W'(dy);
    assign rg = PG_W'(core_radius) * PG_W'(float_gain);
    assign sg = PG_W'(sigma_scale) * PG_W'(float_gain);
    assign r64_next = carrier_fixed ? gpw_pkg::RAD_W'(core_radius) << FIX_SH
                                    : gpw_pkg::RAD_W'(rg) << FLT_SH;
    assign s64_next = carrier_fixed ? gpw_pkg::RAD_W'(sigma_scale) << FIX_SH
                                    : gpw_pkg::RAD_W'(sg) << FLT_SH;

    // Stage 3: distance squared and the exact core test
    assign d2_next = gpw_pkg::D2_W'(ax2_reg) + gpw_pkg::D2_W'(ay2_reg);
    assign d2s     = gpw_pkg::REM_W'(d2_next) << gpw_pkg::D2_SHIFT;

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // Payload stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax_reg        <= ax_next;
            ay_reg        <= ay_next;
            r64_1_reg     <= r64_next;
            s64_1_reg     <= s64_next;
            ax2_reg       <= gpw_pkg::SQ_W'(ax_reg) * gpw_pkg::SQ_W'(ax_reg);
            ay2_reg       <= gpw_pkg::SQ_W'(ay_reg) * gpw_pkg::SQ_W'(ay_reg);
            r2_reg        <= gpw_pkg::RAD2_W'(r64_1_reg) * gpw_pkg::RAD2_W'(r64_1_reg);
            r64_2_reg     <= r64_1_reg;
            s64_2_reg     <= s64_1_reg;
            item_reg.d2   <= d2_next;
            item_reg.core <= d2s < gpw_pkg::REM_W'(r2_reg);
            item_reg.r64  <= r64_2_reg;
            item_reg.s64  <= s64_2_reg;
        end
    end

    assign push_valid = v3_reg;
    assign push_item  = item_reg;

`ifndef SYNTHESIS
    // A finished item that the queue refuses must not be dropped
    a_hold_refused: assert property (@(posedge clk) disable iff (!rst_n)
        (v3_reg && !push_ready) |=> v3_reg)
        else $error("front dropped an item refused by the queue");
`endif

endmodule

[rtl/core/gpw_queue.sv]
// ============================================================================
// gpw_queue: short FIFO between front and back
// Flop based, first word visible at the output, one push and one pop per
// cycle.
// ============================================================================
module gpw_queue #(
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  gpw_pkg::fq_item_t push_item,
    output logic              pop_valid,
    input  logic              pop_ready,
    output gpw_pkg::fq_item_t pop_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gpw_pkg::fq_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push, pop;

    assign push_ready = count_reg != CNT_W'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue fill count beyond depth");

    a_count_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue lost a pushed beat");
`endif

endmodule

[rtl/core/gpw_back.sv]
// ============================================================================
// gpw_back: distance root and normalised excess
// Pipelined square root (one result bit per stage), excess over the
// radius, restoring division by the spread and the squared ratio.
// ============================================================================
module gpw_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  gpw_pkg::fq_item_t             in_item,
    output logic                          out_valid,
    output logic [gpw_pkg::T_W-1:0]       out_t,
    output gpw_pkg::res_flags_t           out_flags
);

    localparam int ROOT_W = gpw_pkg::ROOT_W;
    localparam int REM_W  = gpw_pkg::REM_W;
    localparam int QUO_W  = gpw_pkg::QUO_W;
    localparam int DREM_W = gpw_pkg::DREM_W;
    localparam int TSH    = QUO_W - gpw_pkg::FRAC_W;  // a >= 2^QUO_W test

    // Square root stages
    logic [REM_W-1:0]   sq_rem_reg  [ROOT_W];
    logic [ROOT_W-1:0]  sq_root_reg [ROOT_W];
    gpw_pkg::sq_side_t  sq_side_reg [ROOT_W];
    logic [ROOT_W-1:0]  sq_v_reg;

    genvar g;
    for (g = 0; g < ROOT_W; g++)
    begin : g_sqrt
        localparam int B = ROOT_W - 1 - g;
        logic [REM_W-1:0]   rem_in, trial, rem_next;
        logic [ROOT_W-1:0]  root_in, root_next;
        gpw_pkg::sq_side_t  side_in;
        logic               v_in, ge;

        if (g == 0)
        begin : g_first
            assign rem_in       = REM_W'(in_item.d2) << gpw_pkg::D2_SHIFT;
            assign root_in      = '0;
            assign side_in.core = in_item.core;
            assign side_in.r64  = in_item.r64;
            assign side_in.s64  = in_item.s64;
            assign v_in         = in_valid;
        end
        else
        begin : g_rest
            assign rem_in  = sq_rem_reg[g-1];
            assign root_in = sq_root_reg[g-1];
            assign side_in = sq_side_reg[g-1];
            assign v_in    = sq_v_reg[g-1];
        end

        // Try setting this root bit: (q + 2^B)^2 - q^2 = q*2^(B+1) + 2^(2B)
        assign trial     = (REM_W'(root_in) << (B + 1)) + (REM_W'(1) << (2 * B));
        assign ge        = rem_in >= trial;
        assign rem_next  = ge ? rem_in - trial : rem_in;
        assign root_next = ge ? root_in | (ROOT_W'(1) << B) : root_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                sq_v_reg[g] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_rem_reg[g]  <= rem_next;
                sq_root_reg[g] <= root_next;
                sq_side_reg[g] <= side_in;
            end
        end
    end

    // Divider stages: entry 0 forms the excess, the rest give one bit each
    logic [DREM_W-1:0]  dv_rem_reg  [QUO_W+1];
    logic [QUO_W-1:0]   dv_quo_reg  [QUO_W+1];
    gpw_pkg::dv_side_t  dv_side_reg [QUO_W+1];
    logic [QUO_W:0]     dv_v_reg;

    logic [ROOT_W-1:0]  root_fin, r64_ext, excess;
    gpw_pkg::sq_side_t  side_fin;
    gpw_pkg::dv_side_t  dv_side_next;

    assign root_fin = sq_root_reg[ROOT_W-1];
    assign side_fin = sq_side_reg[ROOT_W-1];
    assign r64_ext  = ROOT_W'(side_fin.r64);
    assign excess   = (root_fin > r64_ext) ? root_fin - r64_ext : '0;

    // Quotient of 2^QUO_W or more is far tail already; covers zero spread too
    assign dv_side_next.core = side_fin.core;
    assign dv_side_next.tail = excess >= (ROOT_W'(side_fin.s64) << TSH);
    assign dv_side_next.s64  = side_fin.s64;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_v_reg[0] <= sq_v_reg[ROOT_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0]  <= DREM_W'(excess) << gpw_pkg::FRAC_W;
            dv_quo_reg[0]  <= '0;
            dv_side_reg[0] <= dv_side_next;
        end
    end

    genvar j;
    for (j = 1; j <= QUO_W; j++)
    begin : g_div
        localparam int B = QUO_W - j;
        logic [DREM_W-1:0] trial, rem_next;
        logic [QUO_W-1:0]  quo_next;
        logic              ge;

        assign trial    = DREM_W'(dv_side_reg[j-1].s64) << B;
        assign ge       = dv_rem_reg[j-1] >= trial;
        assign rem_next = ge ? dv_rem_reg[j-1] - trial : dv_rem_reg[j-1];
        assign quo_next = ge ? dv_quo_reg[j-1] | (QUO_W'(1) << B) : dv_quo_reg[j-1];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                dv_v_reg[j] <= dv_v_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[j]  <= rem_next;
                dv_quo_reg[j]  <= quo_next;
                dv_side_reg[j] <= dv_side_reg[j-1];
            end
        end
    end

    // Square the ratio and apply the far-tail cut
    logic [QUO_W-1:0]         a_fin;
    logic [gpw_pkg::A2_W-1:0] a_sq;
    logic [gpw_pkg::T_W-1:0]  t_reg;
    gpw_pkg::res_flags_t      flags_reg, flags_next;
    logic                     t_v_reg;

    assign a_fin           = dv_quo_reg[QUO_W];
    assign a_sq            = gpw_pkg::A2_W'(a_fin) * gpw_pkg::A2_W'(a_fin);
    assign flags_next.core = dv_side_reg[QUO_W].core;
    assign flags_next.tail = dv_side_reg[QUO_W].tail || (a_fin >= gpw_pkg::TAIL_Q16);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_v_reg <= 1'b0;
        end
        else if (en)
        begin
            t_v_reg <= dv_v_reg[QUO_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t_reg     <= a_sq[gpw_pkg::A2_W-1:gpw_pkg::T_SHIFT];
            flags_reg <= flags_next;
        end
    end

    assign out_valid = t_v_reg;
    assign out_t     = t_reg;
    assign out_flags = flags_reg;

endmodule

[rtl/core/gpw_gauss.sv]
// ============================================================================
// gpw_gauss: exp(-t) in Q30
// Taylor series for the fractional part, three stages per term, then one
// stage per whole unit of t multiplying by e^-1.
// ============================================================================
module gpw_gauss (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [gpw_pkg::T_W-1:0]       in_t,
    input  gpw_pkg::res_flags_t           in_flags,
    output logic                          out_valid,
    output logic [gpw_pkg::ACC_W-1:0]     out_acc,
    output gpw_pkg::res_flags_t           out_flags
);

    localparam int NT     = gpw_pkg::NUM_TERMS;
    localparam int NE     = gpw_pkg::NUM_EXP;
    localparam int TERM_W = gpw_pkg::TERM_W;
    localparam int SUM_W  = gpw_pkg::SUM_W;
    localparam int ACC_W  = gpw_pkg::ACC_W;
    localparam int F_W    = gpw_pkg::FRAC_W;
    localparam int PA_W   = TERM_W + F_W;
    localparam int PB_W   = TERM_W + gpw_pkg::RECIP_W;
    localparam int KR_W   = TERM_W + 4;
    localparam int PE_W   = ACC_W + gpw_pkg::E1_W;

    gpw_pkg::gs_side_t side_first;

    assign side_first.flags = in_flags;
    assign side_first.n     = in_t[gpw_pkg::T_W-1:F_W];
    assign side_first.f     = in_t[F_W-1:0];

    // Taylor stage registers: A multiply by f, B multiply by 1/k, C fix up
    logic [TERM_W-1:0]        ta_p_reg   [NT];
    logic signed [SUM_W-1:0]  ta_sum_reg [NT];
    gpw_pkg::gs_side_t        ta_side_reg[NT];
    logic [NT-1:0]            ta_v_reg;
    logic [TERM_W-1:0]        tb_p_reg   [NT];
    logic [PB_W-1:0]          tb_m_reg   [NT];
    logic signed [SUM_W-1:0]  tb_sum_reg [NT];
    gpw_pkg::gs_side_t        tb_side_reg[NT];
    logic [NT-1:0]            tb_v_reg;
    logic [TERM_W-1:0]        tc_term_reg[NT];
    logic signed [SUM_W-1:0]  tc_sum_reg [NT];
    gpw_pkg::gs_side_t        tc_side_reg[NT];
    logic [NT-1:0]            tc_v_reg;

    genvar g;
    for (g = 0; g < NT; g++)
    begin : g_term
        localparam int K = g + 1;
        logic [TERM_W-1:0]       term_in, q0, term_next;
        logic signed [SUM_W-1:0] sum_in, sum_next;
        gpw_pkg::gs_side_t       side_in;
        logic                    v_in, ge;
        logic [PA_W-1:0]         pa;
        logic [KR_W-1:0]         rem;

        if (g == 0)
        begin : g_first
            assign term_in = gpw_pkg::ONE_Q30;
            assign sum_in  = SUM_W'(gpw_pkg::ONE_Q30);
            assign side_in = side_first;
            assign v_in    = in_valid;
        end
        else
        begin : g_rest
            assign term_in = tc_term_reg[g-1];
            assign sum_in  = tc_sum_reg[g-1];
            assign side_in = tc_side_reg[g-1];
            assign v_in    = tc_v_reg[g-1];
        end

        // term * f in Q30, f taken as Q16
        assign pa = PA_W'(term_in) * PA_W'(side_in.f);

        // Low estimate of p / K is at most one short: fix it with one compare
        assign q0        = tb_m_reg[g][PB_W-1:gpw_pkg::RECIP_W];
        assign rem       = KR_W'(tb_p_reg[g]) - KR_W'(q0) * KR_W'(K);
        assign ge        = rem >= KR_W'(K);
        assign term_next = q0 + TERM_W'(ge);
        assign sum_next  = (K % 2 == 1) ? tb_sum_reg[g] - SUM_W'(term_next)
                                        : tb_sum_reg[g] + SUM_W'(term_next);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ta_v_reg[g] <= 1'b0;
                tb_v_reg[g] <= 1'b0;
                tc_v_reg[g] <= 1'b0;
            end
            else if (en)
            begin
                ta_v_reg[g] <= v_in;
                tb_v_reg[g] <= ta_v_reg[g];
                tc_v_reg[g] <= tb_v_reg[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ta_p_reg[g]    <= pa[PA_W-1:F_W];
                ta_sum_reg[g]  <= sum_in;
                ta_side_reg[g] <= side_in;
                tb_p_reg[g]    <= ta_p_reg[g];
                tb_m_reg[g]    <= PB_W'(ta_p_reg[g]) * PB_W'(gpw_pkg::recip_q32(K));
                tb_sum_reg[g]  <= ta_sum_reg[g];
                tb_side_reg[g] <= ta_side_reg[g];
                tc_term_reg[g] <= term_next;
                tc_sum_reg[g]  <= sum_next;
                tc_side_reg[g] <= tb_side_reg[g];
            end
        end
    end

    // Whole units of t: multiply by e^-1 once per unit
    logic [ACC_W-1:0]    ex_acc_reg  [NE];
    gpw_pkg::gs_side_t   ex_side_reg [NE];
    logic [NE-1:0]       ex_v_reg;

    genvar i;
    for (i = 0; i < NE; i++)
    begin : g_exp
        logic [ACC_W-1:0]  acc_in, acc_next;
        gpw_pkg::gs_side_t side_in;
        logic              v_in;
        logic [PE_W-1:0]   prod;

        if (i == 0)
        begin : g_first
            // Drop a negative series sum to zero
            assign acc_in  = tc_sum_reg[NT-1][SUM_W-1] ? '0 : ACC_W'(tc_sum_reg[NT-1]);
            assign side_in = tc_side_reg[NT-1];
            assign v_in    = tc_v_reg[NT-1];
        end
        else
        begin : g_rest
            assign acc_in  = ex_acc_reg[i-1];
            assign side_in = ex_side_reg[i-1];
            assign v_in    = ex_v_reg[i-1];
        end

        assign prod     = PE_W'(acc_in) * PE_W'(gpw_pkg::E1_Q30);
        assign acc_next = (side_in.n > gpw_pkg::N_W'(i))
                          ? ACC_W'(prod[PE_W-1:gpw_pkg::Q30_SHIFT]) : acc_in;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ex_v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                ex_v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ex_acc_reg[i]  <= acc_next;
                ex_side_reg[i] <= side_in;
            end
        end
    end

    assign out_valid = ex_v_reg[NE-1];
    assign out_acc   = ex_acc_reg[NE-1];
    assign out_flags = ex_side_reg[NE-1].flags;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb: self-checking bench for the GNSS particle weighting core
// Drives particle and fix positions over valid/ready, predicts each weight
// with a local fixed-point model of the likelihood and compares in order.
// Steps through several register settings, extremes among them.
// ============================================================================
module tb;

    localparam int N_ITEMS     = 1550;
    localparam int DRAIN_WAIT  = 130;
    localparam int LONG_HOLD   = 400;

    typedef struct {
        logic signed [gpw_pkg::COORD_W-1:0] px;
        logic signed [gpw_pkg::COORD_W-1:0] py;
        logic signed [gpw_pkg::COORD_W-1:0] gx;
        logic signed [gpw_pkg::COORD_W-1:0] gy;
        logic                               cf;
        bit                                 known;
        logic [gpw_pkg::WEIGHT_W-1:0]       w;
    } particle_row_t;

    typedef struct {
        logic [15:0] radius;
        logic [15:0] sigma;
        logic [16:0] wmin;
        logic [7:0]  gain;
    } weight_cfg_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [gpw_pkg::COORD_W-1:0] particle_x = '0;
    logic signed [gpw_pkg::COORD_W-1:0] particle_y = '0;
    logic signed [gpw_pkg::COORD_W-1:0] gnss_x = '0;
    logic signed [gpw_pkg::COORD_W-1:0] gnss_y = '0;
    logic carrier_fixed = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [gpw_pkg::WEIGHT_W-1:0] weight;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [gpw_pkg::CFG_W-1:0] cfg_wdata = '0;

    weight_cfg_t                   cur_cfg;
    logic [gpw_pkg::WEIGHT_W-1:0]  pending_weights[$];
    int                            n_errors = 0;
    int                            n_sent = 0;
    int                            n_checked = 0;
    int                            sender_idle = 24;
    int                            recv_idle = 68;
    int                            hold_request = 0;

    gnss_particle_weighting_core dut (.*);

    always #4 clk = ~clk;

    // Bound the run
    initial
    begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic report_mismatch(input string what);
        n_errors++;
        $display("ERROR @%0t: %s", $realtime, what);
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // exp(-t) for t in Q16, result in Q16 rounded half up
    function automatic longint unsigned exp_neg_q16(input longint unsigned t);
        longint unsigned whole;
        longint unsigned frac;
        longint unsigned term;
        longint          sum;
        longint unsigned acc;
        whole = t >> 16;
        frac = (t & 64'hFFFF) << 14;
        term = 64'd1073741824;
        sum = 64'sd1073741824;
        for (int k = 1; k <= gpw_pkg::NUM_TERMS; k++)
        begin
            term = ((term * frac) >> 30) / k;
            if (k % 2 == 1) sum -= longint'(term);
            else sum += longint'(term);
        end
        acc = sum > 0 ? longint'(sum) : 0;
        for (longint unsigned k = 0; k < whole; k++)
            acc = (acc * 64'd395007542) >> 30;
        return (acc + 8192) >> 14;
    endfunction

    function automatic logic [gpw_pkg::WEIGHT_W-1:0] particle_weight(input particle_row_t p);
        longint dx, dy;
        longint unsigned ax, ay, d2s, r64, s64, w, dd, e, a;
        dx = longint'(p.px) - longint'(p.gx);
        dy = longint'(p.py) - longint'(p.gy);
        ax = dx < 0 ? -dx : dx;
        ay = dy < 0 ? -dy : dy;
        d2s = (ax * ax + ay * ay) * 4096;
        if (p.cf)
        begin
            r64 = cur_cfg.radius * 64;
            s64 = cur_cfg.sigma * 64;
        end
        else
        begin
            r64 = longint'(cur_cfg.radius) * cur_cfg.gain * 4;
            s64 = longint'(cur_cfg.sigma) * cur_cfg.gain * 4;
        end
        if (d2s < r64 * r64)
            w = 65536;
        else if (s64 == 0)
            w = 0;
        else
        begin
            dd = int_sqrt(d2s);
            e = dd > r64 ? dd - r64 : 0;
            a = (e << 16) / s64;
            if (a >= 327680) w = 0;
            else w = exp_neg_q16((a * a) >> 17);
        end
        if (w < cur_cfg.wmin) w = cur_cfg.wmin;
        return w[gpw_pkg::WEIGHT_W-1:0];
    endfunction

    // Receiver: random stalls, plus one long hold on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
                out_ready = ($urandom_range(99) >= recv_idle);
        end
    end

    // Check each output beat against the oldest expected weight
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_weights.size() == 0)
                report_mismatch($sformatf("unexpected weight %0d", weight));
            else
            begin
                logic [gpw_pkg::WEIGHT_W-1:0] exp_w;
                exp_w = pending_weights.pop_front();
                n_checked++;
                if (weight !== exp_w)
                    report_mismatch($sformatf("weight %0d, expected %0d", weight, exp_w));
            end
        end
    end

    task automatic set_idling();
        if (n_sent < N_ITEMS / 3)
        begin
            sender_idle = 24;
            recv_idle = 68;
        end
        else if (n_sent < 2 * N_ITEMS / 3)
        begin
            sender_idle = 68;
            recv_idle = 24;
        end
        else
        begin
            sender_idle = 0;
            recv_idle = 0;
        end
    endtask

    // Offer one beat, hold it until accepted; called at a falling edge
    task automatic send_particle(input particle_row_t p);
        logic [gpw_pkg::WEIGHT_W-1:0] exp_w;
        set_idling();
        while ($urandom_range(99) < sender_idle)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        exp_w = particle_weight(p);
        if (p.known && exp_w !== p.w)
            report_mismatch($sformatf("table row expects %0d, model gives %0d", p.w, exp_w));
        in_valid = 1'b1;
        particle_x = p.px;
        particle_y = p.py;
        gnss_x = p.gx;
        gnss_y = p.gy;
        carrier_fixed = p.cf;
        do @(posedge clk); while (!in_ready);
        exp_w = p.known ? p.w : exp_w;
        pending_weights = {pending_weights, exp_w};
        n_sent++;
        @(negedge clk);
    endtask

    // Wait until all weights are back and the pipeline is empty
    task automatic drain();
        in_valid = 1'b0;
        while (pending_weights.size() != 0) @(negedge clk);
        repeat (DRAIN_WAIT) @(negedge clk);
    endtask

    task automatic write_reg(input gpw_pkg::cfg_reg_t idx,
                             input logic [gpw_pkg::CFG_W-1:0] val);
        cfg_wr_en = 1'b1;
        cfg_addr = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        case (idx)
            gpw_pkg::REG_CORE_RADIUS: cur_cfg.radius = val[15:0];
            gpw_pkg::REG_SIGMA_SCALE: cur_cfg.sigma = val[15:0];
            gpw_pkg::REG_MIN_WEIGHT:  cur_cfg.wmin = val;
            gpw_pkg::REG_FLOAT_GAIN:  cur_cfg.gain = val[7:0];
            default: ;
        endcase
    endtask

    function automatic particle_row_t random_particle();
        particle_row_t p;
        logic [31:0] off;
        int sh;
        p.gx = gpw_pkg::COORD_W'($urandom);
        p.gy = gpw_pkg::COORD_W'($urandom);
        p.cf = 1'($urandom_range(1));
        p.known = 1'b0;
        p.w = '0;
        if ($urandom_range(9) < 2)
        begin
            p.px = gpw_pkg::COORD_W'($urandom);
            p.py = gpw_pkg::COORD_W'($urandom);
        end
        else
        begin
            // offset spread over every scale from sub-radius to far tail
            sh = $urandom_range(24);
            off = $urandom_range(0, 1 << sh);
            p.px = gpw_pkg::COORD_W'(p.gx + ($urandom_range(1) ? -int'(off) : int'(off)));
            sh = $urandom_range(24);
            off = $urandom_range(0, 1 << sh);
            p.py = gpw_pkg::COORD_W'(p.gy + ($urandom_range(1) ? -int'(off) : int'(off)));
        end
        return p;
    endfunction

    // Directed rows under reset settings
    particle_row_t directed[] = '{
        '{25'sd0, 25'sd0, 25'sd0, 25'sd0, 1'b1, 1'b1, 17'd65536},
        '{25'sd16777215, 25'sd16777215, -25'sd16777216, -25'sd16777216, 1'b1, 1'b1, 17'd655},
        '{-25'sd16777216, -25'sd16777216, 25'sd16777215, 25'sd16777215, 1'b0, 1'b1, 17'd655},
        '{25'sd100, -25'sd50, 25'sd100, -25'sd50, 1'b0, 1'b1, 17'd65536},
        '{25'sd255, 25'sd0, 25'sd0, 25'sd0, 1'b1, 1'b1, 17'd65536},
        '{25'sd256, 25'sd0, 25'sd0, 25'sd0, 1'b1, 1'b0, 17'd0},
        '{25'sd0, 25'sd511, 25'sd0, 25'sd0, 1'b0, 1'b1, 17'd65536},
        '{25'sd0, 25'sd512, 25'sd0, 25'sd0, 1'b0, 1'b0, 17'd0},
        '{25'sd6656, 25'sd0, 25'sd0, 25'sd0, 1'b1, 1'b0, 17'd0},
        '{-25'sd3000, 25'sd4000, 25'sd0, 25'sd0, 1'b1, 1'b0, 17'd0},
        '{25'sd20000, 25'sd9000, -25'sd1, 25'sd1, 1'b0, 1'b0, 17'd0},
        '{25'sd32768, 25'sd32768, 25'sd0, 25'sd0, 1'b1, 1'b0, 17'd0},
        '{-25'sd1, -25'sd1, 25'sd16777215, -25'sd16777216, 1'b0, 1'b1, 17'd655},
        '{25'sd0, 25'sd0, 25'sd40000, 25'sd0, 1'b1, 1'b0, 17'd0},
        '{25'sd0, 25'sd0, 25'sd0, -25'sd80000, 1'b0, 1'b0, 17'd0}
    };

    // Register settings per phase: radius, sigma, min weight, gain
    weight_cfg_t phases[] = '{
        '{16'd0, 16'd6400, 17'd655, 8'd32},
        '{16'd256, 16'd0, 17'd0, 8'd16},
        '{16'd65535, 16'd65535, 17'd65536, 8'd255},
        '{16'd512, 16'd1, 17'd131071, 8'd0},
        '{16'd100, 16'd300, 17'd1000, 8'd8},
        '{16'd1024, 16'd2048, 17'd20000, 8'd48}
    };

    // Main sequence
    initial
    begin
        int per_phase;
        cur_cfg = '{16'd256, 16'd6400, 17'd655, 8'd32};
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i]) send_particle(directed[i]);

        per_phase = N_ITEMS / (phases.size() + 1);
        for (int ph = 0; ph <= phases.size(); ph++)
        begin
            if (ph > 0)
            begin
                drain();
                write_reg(gpw_pkg::REG_CORE_RADIUS, phases[ph-1].radius);
                write_reg(gpw_pkg::REG_SIGMA_SCALE, phases[ph-1].sigma);
                write_reg(gpw_pkg::REG_MIN_WEIGHT, phases[ph-1].wmin);
                write_reg(gpw_pkg::REG_FLOAT_GAIN, phases[ph-1].gain);
            end
            // fill the pipe against a long receiver hold
            if (ph == 2) hold_request = LONG_HOLD;
            for (int i = 0; i < per_phase; i++) send_particle(random_particle());
        end
        drain();

        $display("Sent %0d particles over %0d register settings, %0d weights checked.",
                 n_sent, phases.size() + 1, n_checked);
        $display("Covered core, Gaussian slope, far tail, zero radius/spread and clamps.");
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
